// ===== hdl/shvs_pkg.sv =====
// shared types and constants for the sequential-halving visit schedule unit
// no dependencies; used by every other file of the block except shvs_divider
package shvs_pkg;

   localparam int VISIT_W     = 12;
   localparam int CFG_LIMIT_W = 7;
   localparam int CFG_SIMS_W  = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;

   localparam int DEF_MAX_CONSIDERED  = 64;
   localparam int DEF_MAX_SIMULATIONS = 4096;

   localparam logic [CSR_INDEX_W-1:0] REG_CONSIDERED_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIMULATION_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] NUM_REGS             = 2'd2;

   localparam logic [CFG_LIMIT_W-1:0] CFG_LIMIT_RESET = 7'd4;
   localparam logic [CFG_SIMS_W-1:0]  CFG_SIMS_RESET  = 13'd800;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START_DIV,
      ST_START_WAIT,
      ST_IDLE,
      ST_LEVEL_DIV,
      ST_LEVEL_WAIT
   } state_type;

   typedef struct packed {
      logic cfg_write;
      logic load_start;
      logic div_start;
      logic save_start;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic level_change;
      logic csr_hit;
   } status_type;

endpackage

// ===== hdl/shvs_if.sv =====
// channel interfaces: request, response and register write
// depends on shvs_pkg for payload widths
interface shvs_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface shvs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [shvs_pkg::VISIT_W-1:0]  visit_value;
   logic                          last;
   modport source (output valid, output visit_value, output last, input ready);
   modport sink (input valid, input visit_value, input last, output ready);
endinterface

interface shvs_csr_if;
   logic                             valid;
   logic                             ready;
   logic [shvs_pkg::CSR_INDEX_W-1:0] index;
   logic [shvs_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/shvs_divider.sv =====
// iterative restoring divider, one quotient bit per cycle
// no package dependencies
module shvs_divider #(
   parameter int DIVIDEND_W = 13,
   parameter int DIVISOR_W  = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      ge      = shifted >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/shvs_datapath.sv =====
// schedule counters, register file, output register and repeat-count divider
// depends on shvs_pkg and shvs_divider
module shvs_datapath #(
   parameter int MAX_CONSIDERED  = shvs_pkg::DEF_MAX_CONSIDERED,
   parameter int MAX_SIMULATIONS = shvs_pkg::DEF_MAX_SIMULATIONS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  shvs_pkg::cmd_type                cmd,
   output shvs_pkg::status_type             status,
   input  logic                             req_restart,
   input  logic [shvs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [shvs_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic [shvs_pkg::VISIT_W-1:0]     visit_value,
   output logic                             last
);

   localparam int LIM_W  = $clog2(MAX_CONSIDERED + 1);
   localparam int SIM_W  = $clog2(MAX_SIMULATIONS + 1);
   localparam int LOG_W  = $clog2(LIM_W + 1);
   localparam int DIV_W  = LOG_W + LIM_W;
   localparam int LCMP_W = LIM_W > shvs_pkg::CFG_LIMIT_W ? LIM_W : shvs_pkg::CFG_LIMIT_W;
   localparam int SCMP_W = SIM_W > shvs_pkg::CFG_SIMS_W ? SIM_W : shvs_pkg::CFG_SIMS_W;
   localparam logic [LIM_W-1:0] NOW_FLOOR = LIM_W'(2);

   logic [shvs_pkg::CFG_LIMIT_W-1:0] cfg_limit_ff;
   logic [shvs_pkg::CFG_SIMS_W-1:0]  cfg_sims_ff;

   logic [LIM_W-1:0] lim_ff, now_ff, group_ff;
   logic [LOG_W-1:0] ceil_ff;
   logic [SIM_W-1:0] sims_ff, start_rep_ff, reps_ff, rep_pos_ff, level_ff, emitted_ff;
   logic [shvs_pkg::VISIT_W-1:0] visit_ff;
   logic                         last_ff;

   logic [LCMP_W-1:0] lim_wide;
   logic [SCMP_W-1:0] sims_wide;
   logic [LIM_W-1:0]  eff_lim;
   logic [SIM_W-1:0]  eff_sims;
   logic [LOG_W-1:0]  ceil_log2;

   logic [LIM_W-1:0] cur_now, cur_group, n_now, n_group, g1, half_now;
   logic [SIM_W-1:0] cur_reps, cur_rep, cur_level, cur_emitted;
   logic [SIM_W-1:0] n_rep, n_level, n_emitted, r1, value;
   logic             level_chg, step_last;

   logic [DIV_W-1:0] divisor;
   logic [SIM_W-1:0] quotient, q_fix;
   logic             div_done;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_limit_ff <= shvs_pkg::CFG_LIMIT_RESET;
         cfg_sims_ff  <= shvs_pkg::CFG_SIMS_RESET;
      end else if (cmd.cfg_write) begin
         case (csr_index)
            shvs_pkg::REG_CONSIDERED_LIMIT: cfg_limit_ff <= csr_data[shvs_pkg::CFG_LIMIT_W-1:0];
            shvs_pkg::REG_SIMULATION_COUNT: cfg_sims_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // clamping and ceil log2 of the effective limit
   always_comb begin
      lim_wide  = LCMP_W'(cfg_limit_ff);
      sims_wide = SCMP_W'(cfg_sims_ff);
      eff_lim   = (lim_wide > LCMP_W'(MAX_CONSIDERED)) ? LIM_W'(MAX_CONSIDERED)
                                                       : LIM_W'(lim_wide);
      if (sims_wide == '0)
         eff_sims = SIM_W'(1);
      else if (sims_wide > SCMP_W'(MAX_SIMULATIONS))
         eff_sims = SIM_W'(MAX_SIMULATIONS);
      else
         eff_sims = SIM_W'(sims_wide);
      ceil_log2 = '0;
      for (int j = 0; j < LIM_W; j++) begin
         if ((LIM_W'(1) << j) < eff_lim)
            ceil_log2 = ceil_log2 + 1'b1;
      end
   end

   // one schedule step, starting over first when restart is set
   always_comb begin
      cur_now     = req_restart ? lim_ff       : now_ff;
      cur_group   = req_restart ? '0           : group_ff;
      cur_reps    = req_restart ? start_rep_ff : reps_ff;
      cur_rep     = req_restart ? '0           : rep_pos_ff;
      cur_level   = req_restart ? '0           : level_ff;
      cur_emitted = req_restart ? '0           : emitted_ff;
      n_now     = cur_now;
      n_group   = cur_group;
      n_rep     = cur_rep;
      n_level   = cur_level;
      level_chg = 1'b0;
      g1        = cur_group + 1'b1;
      r1        = cur_rep + 1'b1;
      half_now  = cur_now >> 1;
      if (lim_ff <= LIM_W'(1)) begin
         value = cur_emitted;
      end else begin
         value = cur_level;
         if (g1 >= cur_now) begin
            n_group = '0;
            n_level = cur_level + 1'b1;
            if (r1 >= cur_reps) begin
               n_rep     = '0;
               n_now     = (half_now < NOW_FLOOR) ? NOW_FLOOR : half_now;
               level_chg = 1'b1;
            end else begin
               n_rep = r1;
            end
         end else begin
            n_group = g1;
         end
      end
      n_emitted = cur_emitted + 1'b1;
      step_last = n_emitted >= sims_ff;
   end

   assign divisor = DIV_W'(ceil_ff) * DIV_W'(now_ff);
   // a zero quotient counts as one repeat
   assign q_fix   = (quotient == '0) ? SIM_W'(1) : quotient;

   shvs_divider #(
      .DIVIDEND_W (SIM_W),
      .DIVISOR_W  (DIV_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sims_ff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_start) begin
         lim_ff     <= eff_lim;
         ceil_ff    <= ceil_log2;
         sims_ff    <= eff_sims;
         now_ff     <= eff_lim;
         group_ff   <= '0;
         rep_pos_ff <= '0;
         level_ff   <= '0;
         emitted_ff <= '0;
      end else if (cmd.step) begin
         visit_ff <= shvs_pkg::VISIT_W'(value);
         last_ff  <= step_last;
         if (step_last) begin
            now_ff     <= lim_ff;
            reps_ff    <= start_rep_ff;
            group_ff   <= '0;
            rep_pos_ff <= '0;
            level_ff   <= '0;
            emitted_ff <= '0;
         end else begin
            now_ff     <= n_now;
            reps_ff    <= cur_reps;
            group_ff   <= n_group;
            rep_pos_ff <= n_rep;
            level_ff   <= n_level;
            emitted_ff <= n_emitted;
         end
      end else if (div_done) begin
         reps_ff <= q_fix;
         if (cmd.save_start)
            start_rep_ff <= q_fix;
      end
   end

   always_comb begin
      status.div_done     = div_done;
      status.level_change = level_chg && !step_last;
      status.csr_hit      = csr_index < shvs_pkg::NUM_REGS;
   end

   assign visit_value = visit_ff;
   assign last        = last_ff;

endmodule

// ===== hdl/shvs_ctrl.sv =====
// controller state machine: start-up divide, request handshake, level-change divide
// depends on shvs_pkg
module shvs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  shvs_pkg::status_type status,
   output shvs_pkg::cmd_type    cmd
);

   shvs_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shvs_pkg::ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      accept    = 1'b0;
      case (state_ff)
         shvs_pkg::ST_LOAD: begin
            cmd.load_start = 1'b1;
            state_in       = shvs_pkg::ST_START_DIV;
         end
         shvs_pkg::ST_START_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = shvs_pkg::ST_START_WAIT;
         end
         shvs_pkg::ST_START_WAIT: begin
            cmd.save_start = 1'b1;
            if (status.div_done)
               state_in = shvs_pkg::ST_IDLE;
         end
         shvs_pkg::ST_IDLE: begin
            csr_ready     = 1'b1;
            req_ready     = !csr_valid && (!rsp_valid_ff || rsp_ready);
            accept        = req_valid && req_ready;
            cmd.cfg_write = csr_valid;
            cmd.step      = accept;
            if (csr_valid && status.csr_hit)
               state_in = shvs_pkg::ST_LOAD;
            else if (accept && status.level_change)
               state_in = shvs_pkg::ST_LEVEL_DIV;
         end
         shvs_pkg::ST_LEVEL_DIV: begin
            cmd.div_start = 1'b1;
            state_in      = shvs_pkg::ST_LEVEL_WAIT;
         end
         shvs_pkg::ST_LEVEL_WAIT: begin
            if (status.div_done)
               state_in = shvs_pkg::ST_IDLE;
         end
         default: state_in = shvs_pkg::ST_LOAD;
      endcase
      // output register frees as soon as the beat is taken
      if (accept)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == shvs_pkg::ST_START_WAIT ||
                           state_ff == shvs_pkg::ST_LEVEL_WAIT))
      else $error("divider finished outside a wait state");

   a_level_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == shvs_pkg::ST_IDLE && accept && status.level_change && !csr_valid)
      |=> state_ff == shvs_pkg::ST_LEVEL_DIV)
      else $error("level change did not start a divide");

   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && status.csr_hit) |=> state_ff == shvs_pkg::ST_LOAD)
      else $error("register write did not restart the schedule");

   a_no_req_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != shvs_pkg::ST_IDLE) |-> (!req_ready && !csr_ready))
      else $error("handshake open while a divide is running");

endmodule

// ===== hdl/sequential_halving_visit_schedule_unit.sv =====
// sequential-halving visit schedule unit: one result beat per request beat
// result: registered and offered in the cycle after the request is taken
// throughput: one request per cycle within a level while the response side takes each beat and no
// register write is pending; a level change costs the repeat-count divide, one quotient bit a cycle
// reset and every write to a defined register restart the schedule: load plus divide before the
// first request is taken; synchronous active-high reset
module sequential_halving_visit_schedule_unit #(
   parameter int MAX_CONSIDERED  = shvs_pkg::DEF_MAX_CONSIDERED,
   parameter int MAX_SIMULATIONS = shvs_pkg::DEF_MAX_SIMULATIONS
) (
   input logic          clock,
   input logic          reset,
   shvs_req_if.sink     req_if,
   shvs_rsp_if.source   rsp_if,
   shvs_csr_if.sink     csr_if
);

   shvs_pkg::cmd_type    cmd;
   shvs_pkg::status_type status;

   shvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .csr_valid (csr_if.valid),
      .csr_ready (csr_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   shvs_datapath #(
      .MAX_CONSIDERED  (MAX_CONSIDERED),
      .MAX_SIMULATIONS (MAX_SIMULATIONS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_restart (req_if.restart),
      .csr_index   (csr_if.index),
      .csr_data    (csr_if.data),
      .visit_value (rsp_if.visit_value),
      .last        (rsp_if.last)
   );

endmodule
